// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files that check their own behavior.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EIE_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EIE_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/eie_pkg.sv -----
`default_nettype none

package eie_pkg;

    // One word on the byte channel.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } in_word_t;

    // One word on the result channel.
    typedef struct packed {
        logic [47:0] station_mac;
        logic [63:0] name_chunk;
        logic [1:0]  chunk_index;
        logic        last_of_record;
    } out_word_t;

    localparam int CHUNK_BYTES = 8;
    localparam int CHUNK_BITS  = 64;
    localparam int MAX_CHUNKS  = 4;

    // Frame offsets of the fields that are checked or captured.
    localparam logic [15:0] POS_MAC_FIRST   = 16'd6;
    localparam logic [15:0] POS_MAC_LAST    = 16'd11;
    localparam logic [15:0] POS_ETYPE_HI    = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO    = 16'd13;
    localparam logic [15:0] POS_EAPOL_TYPE  = 16'd15;
    localparam logic [15:0] POS_EAP_CODE    = 16'd18;
    localparam logic [15:0] POS_EAP_LEN_HI  = 16'd20;
    localparam logic [15:0] POS_EAP_LEN_LO  = 16'd21;
    localparam logic [15:0] POS_EAP_TYPE    = 16'd22;
    localparam logic [15:0] POS_NAME_START  = 16'd23;
    localparam logic [15:0] POS_MAX         = 16'hFFFF;

    localparam logic [7:0]  ETYPE_HI          = 8'h88;
    localparam logic [7:0]  ETYPE_LO          = 8'h8E;
    localparam logic [7:0]  EAPOL_TYPE_EAP    = 8'd0;
    localparam logic [7:0]  EAP_CODE_RESPONSE = 8'd2;
    localparam logic [7:0]  EAP_TYPE_IDENTITY = 8'd1;
    localparam logic [15:0] EAP_HDR_LEN       = 16'd5;

endpackage

`default_nettype wire

// ----- hw/rtl/eie_parser.sv -----
`default_nettype none

module eie_parser #(
    parameter int NAME_BYTES = 32,
    parameter int CHUNKS     = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   step,
    input  wire eie_pkg::in_word_t                      word,
    output logic                                        rec_load,
    output logic [47:0]                                 rec_mac,
    output logic [CHUNKS*eie_pkg::CHUNK_BITS-1:0]       rec_name
);

    // Only the bytes that can ever be emitted are kept.
    localparam int STORE_BYTES = (NAME_BYTES < CHUNKS * eie_pkg::CHUNK_BYTES) ?
                                 NAME_BYTES : CHUNKS * eie_pkg::CHUNK_BYTES;
    localparam int IDX_W       = $clog2(STORE_BYTES);

    logic [15:0] pos_reg, pos_next;
    logic [47:0] mac_reg, mac_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [15:0] eap_len_reg, eap_len_next;
    logic [7:0]  name_reg [STORE_BYTES];
    logic [7:0]  name_wr [STORE_BYTES];
    logic [7:0]  name_next [STORE_BYTES];

    logic [15:0]      name_off;
    logic [IDX_W-1:0] name_idx;
    logic             name_store;

    assign name_off = pos_reg - eie_pkg::POS_NAME_START;
    assign name_idx = name_off[IDX_W-1:0];

    // A name byte is kept if it lies in the buffer and inside the identity,
    // that is before offset EAP length + 18 of the frame.
    assign name_store = (pos_reg >= eie_pkg::POS_NAME_START)
                     && (name_off < 16'(STORE_BYTES))
                     && (eap_len_reg > eie_pkg::EAP_HDR_LEN)
                     && ({1'b0, pos_reg} <
                         ({1'b0, eap_len_reg} + 17'(eie_pkg::POS_NAME_START)
                          - 17'(eie_pkg::EAP_HDR_LEN)));

    always_comb
    begin
        mac_next     = mac_reg;
        hdr_ok_next  = hdr_ok_reg;
        eap_len_next = eap_len_reg;
        pos_next     = pos_reg;
        rec_load     = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            name_wr[i] = name_reg[i];
        end

        if (step)
        begin
            if (pos_reg >= eie_pkg::POS_MAC_FIRST && pos_reg <= eie_pkg::POS_MAC_LAST)
            begin
                mac_next = {mac_reg[39:0], word.frame_byte};
            end
            else if (pos_reg == eie_pkg::POS_ETYPE_HI && word.frame_byte != eie_pkg::ETYPE_HI)
            begin
                hdr_ok_next = 1'b0;
            end
            else if (pos_reg == eie_pkg::POS_ETYPE_LO && word.frame_byte != eie_pkg::ETYPE_LO)
            begin
                hdr_ok_next = 1'b0;
            end
            else if (pos_reg == eie_pkg::POS_EAPOL_TYPE
                     && word.frame_byte != eie_pkg::EAPOL_TYPE_EAP)
            begin
                hdr_ok_next = 1'b0;
            end
            else if (pos_reg == eie_pkg::POS_EAP_CODE
                     && word.frame_byte != eie_pkg::EAP_CODE_RESPONSE)
            begin
                hdr_ok_next = 1'b0;
            end
            else if (pos_reg == eie_pkg::POS_EAP_LEN_HI)
            begin
                eap_len_next = {word.frame_byte, eap_len_reg[7:0]};
            end
            else if (pos_reg == eie_pkg::POS_EAP_LEN_LO)
            begin
                eap_len_next = {eap_len_reg[15:8], word.frame_byte};
            end
            else if (pos_reg == eie_pkg::POS_EAP_TYPE
                     && word.frame_byte != eie_pkg::EAP_TYPE_IDENTITY)
            begin
                hdr_ok_next = 1'b0;
            end
            else if (name_store)
            begin
                name_wr[name_idx] = word.frame_byte;
            end

            pos_next = (pos_reg == eie_pkg::POS_MAX) ? pos_reg : pos_reg + 16'd1;

            if (word.end_of_frame)
            begin
                // The frame must reach the identity type byte to count.
                rec_load = hdr_ok_next && (pos_reg >= eie_pkg::POS_EAP_TYPE)
                        && (eap_len_next > eie_pkg::EAP_HDR_LEN);
                pos_next     = 16'd0;
                hdr_ok_next  = 1'b1;
                eap_len_next = 16'd0;
            end
        end

        for (int i = 0; i < STORE_BYTES; i++)
        begin
            name_next[i] = (step && word.end_of_frame) ? 8'd0 : name_wr[i];
        end
    end

    always_comb
    begin
        rec_mac  = mac_next;
        rec_name = '0;
        for (int j = 0; j < STORE_BYTES; j++)
        begin
            rec_name[8*j +: 8] = name_wr[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 16'd0;
            mac_reg     <= 48'd0;
            hdr_ok_reg  <= 1'b1;
            eap_len_reg <= 16'd0;
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                name_reg[i] <= 8'd0;
            end
        end
        else
        begin
            pos_reg     <= pos_next;
            mac_reg     <= mac_next;
            hdr_ok_reg  <= hdr_ok_next;
            eap_len_reg <= eap_len_next;
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                name_reg[i] <= name_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/eie_emitter.sv -----
`default_nettype none

module eie_emitter #(
    parameter int CHUNKS = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   rec_load,
    input  wire logic [47:0]                            rec_mac,
    input  wire logic [CHUNKS*eie_pkg::CHUNK_BITS-1:0]  rec_name,
    output logic                                        rec_busy,
    output logic                                        result_valid,
    input  wire logic                                   result_stall,
    output eie_pkg::out_word_t                          result_word
);

    localparam int         NAME_W     = CHUNKS * eie_pkg::CHUNK_BITS;
    localparam logic [1:0] LAST_CHUNK = 2'(CHUNKS - 1);

    logic              valid_reg, valid_next;
    logic [1:0]        chunk_reg, chunk_next;
    logic [47:0]       mac_reg;
    logic [NAME_W-1:0] name_reg;
    logic              taken;
    logic              last;

    assign last  = (chunk_reg == LAST_CHUNK);
    assign taken = valid_reg && !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        chunk_next = chunk_reg;
        if (rec_load)
        begin
            valid_next = 1'b1;
            chunk_next = 2'd0;
        end
        else if (taken)
        begin
            valid_next = !last;
            chunk_next = chunk_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            chunk_reg <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            chunk_reg <= chunk_next;
        end
    end

    // The record shifts down one chunk per delivered word.
    always_ff @(posedge clk)
    begin
        if (rec_load)
        begin
            mac_reg  <= rec_mac;
            name_reg <= rec_name;
        end
        else if (taken)
        begin
            name_reg <= name_reg >> eie_pkg::CHUNK_BITS;
        end
    end

    assign rec_busy                   = valid_reg;
    assign result_valid               = valid_reg;
    assign result_word.station_mac    = mac_reg;
    assign result_word.name_chunk     = name_reg[eie_pkg::CHUNK_BITS-1:0];
    assign result_word.chunk_index    = chunk_reg;
    assign result_word.last_of_record = last;

endmodule

`default_nettype wire

// ----- hw/rtl/eap_identity_extractor.sv -----
// Channel | Dir | Word fields                                         | Handshake
// --------+-----+-----------------------------------------------------+----------------------------
// byte    | in  | frame_byte, end_of_frame                            | byte_valid, byte_stall
// result  | out | station_mac, name_chunk, chunk_index, last_of_record | result_valid, result_stall
//
// A byte word is accepted in every cycle that byte_stall is low and is parsed in the next, out of the input register,
// unless it is a frame end that byte_stall holds there. A matching frame end loads a record at that parse edge;
// the record leaves as ceil(NAME_BYTES/8) words (at most 4), one per cycle while result_stall is low.
// byte_stall rises only while a frame-end word waits for the previous record to finish, which result_stall can prolong.
// Reset is asynchronous and active low; it clears the parse state, name buffer and valid flags.
`default_nettype none
`include "assert_macros.svh"

module eap_identity_extractor #(
    parameter int NAME_BYTES = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire eie_pkg::in_word_t  byte_word,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output eie_pkg::out_word_t      result_word
);

    // Chunk count of a record, limited by the two-bit chunk index.
    localparam int RAW_CHUNKS = (NAME_BYTES + eie_pkg::CHUNK_BYTES - 1) / eie_pkg::CHUNK_BYTES;
    localparam int CHUNKS     = (RAW_CHUNKS < eie_pkg::MAX_CHUNKS) ?
                                RAW_CHUNKS : eie_pkg::MAX_CHUNKS;

    // Input register: holds one word until the parser can take it.
    logic              in_valid_reg, in_valid_next;
    eie_pkg::in_word_t in_word_reg;
    logic              take;
    logic              step;
    logic              rec_load;
    logic              rec_busy;
    logic [47:0]       rec_mac;
    logic [CHUNKS*eie_pkg::CHUNK_BITS-1:0] rec_name;

    // Only a frame end can produce a record, so only that word has to wait
    // for the emitter; every other byte moves on at once.
    assign byte_stall    = in_valid_reg && in_word_reg.end_of_frame && rec_busy;
    assign step          = in_valid_reg && !byte_stall;
    assign take          = byte_valid && !byte_stall;
    assign in_valid_next = take || (in_valid_reg && byte_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= byte_word;
        end
    end

    eie_parser #(
        .NAME_BYTES (NAME_BYTES),
        .CHUNKS     (CHUNKS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .word     (in_word_reg),
        .rec_load (rec_load),
        .rec_mac  (rec_mac),
        .rec_name (rec_name)
    );

    eie_emitter #(
        .CHUNKS (CHUNKS)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_load     (rec_load),
        .rec_mac      (rec_mac),
        .rec_name     (rec_name),
        .rec_busy     (rec_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    // A new record never overwrites one that is still being delivered.
    `EIE_ASSERT_SAME(a_load_when_idle, rec_load, !rec_busy)
    // A record keeps its words coming until the last one is taken.
    `EIE_ASSERT_NEXT(a_record_continues,
        result_valid && !result_stall && !result_word.last_of_record, result_valid)
    // Taking the last word leaves the result channel empty in the next cycle.
    `EIE_ASSERT_NEXT(a_gap_after_record,
        result_valid && !result_stall && result_word.last_of_record, !result_valid)
    // A held frame end stays in the input register unchanged.
    `EIE_ASSERT_NEXT(a_held_word_kept, byte_stall,
        in_valid_reg && in_word_reg.end_of_frame && $stable(in_word_reg))

endmodule

`default_nettype wire
